/* hdl/mdhf_pkg.sv */
// Package for the masked depth hole fill block: types, codes and defaults.
package mdhf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int DEPTH_W   = 16;
    localparam int MASK_W    = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [MASK_W-1:0] MASK_THRESH = 8'd128;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_in;
        logic [MASK_W-1:0]  mask_level;
    } t_in;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_out;
        logic               frame_last;
    } t_out;

    // Position flags for the pixel being transferred in.
    typedef struct packed {
        logic inner;
        logic frame_last;
    } t_pos_flags;

endpackage

/* hdl/mdhf_line_store.sv */
// Line store: one row of final depths, one write port, one registered read port.
module mdhf_line_store #(
    parameter int DEPTH = mdhf_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(mdhf_pkg::MAX_WIDTH_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [mdhf_pkg::DEPTH_W-1:0] o_rd_data,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [mdhf_pkg::DEPTH_W-1:0] i_wr_data
);
    import mdhf_pkg::*;

    logic [DEPTH_W-1:0] r_mem [DEPTH];
    logic [DEPTH_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/mdhf_pos.sv */
// Frame geometry registers and raster position counters.
module mdhf_pos #(
    parameter int MAX_WIDTH  = mdhf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mdhf_pkg::MAX_HEIGHT_DEF,
    parameter int CLW        = $clog2(mdhf_pkg::MAX_WIDTH_DEF),
    parameter int RLW        = $clog2(mdhf_pkg::MAX_HEIGHT_DEF)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mdhf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mdhf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_advance,
    output logic [CLW-1:0]                 o_col,
    output mdhf_pkg::t_pos_flags           o_flags
);
    import mdhf_pkg::*;

    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (WDW > CFG_W) ? WDW : CFG_W;
    localparam int HCW = (HDW > CFG_W) ? HDW : CFG_W;

    logic [CFG_W-1:0] r_width, r_height;
    logic [CLW-1:0]   r_col, n_col;
    logic [RLW-1:0]   r_row, n_row;

    logic [WCW-1:0] width_ext, width_use, width_lim;
    logic [HCW-1:0] height_ext, height_use, height_lim;
    logic           row_end, frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp geometry to the supported range.
    always_comb begin
        width_ext  = WCW'(r_width);
        height_ext = HCW'(r_height);
        priority if (width_ext < WCW'(2))               width_use = WCW'(2);
        else if (width_ext > WCW'(MAX_WIDTH))           width_use = WCW'(MAX_WIDTH);
        else                                            width_use = width_ext;
        priority if (height_ext < HCW'(2))              height_use = HCW'(2);
        else if (height_ext > HCW'(MAX_HEIGHT))         height_use = HCW'(MAX_HEIGHT);
        else                                            height_use = height_ext;
        width_lim  = width_use - WCW'(1);
        height_lim = height_use - HCW'(1);
        row_end    = WCW'(r_col) >= width_lim;
        frame_end  = row_end && (HCW'(r_row) >= height_lim);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + RLW'(1);
            end else begin
                n_col = r_col + CLW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col              = r_col;
    assign o_flags.inner      = (r_row != '0) && (r_col != '0);
    assign o_flags.frame_last = frame_end;

endmodule

/* hdl/masked_depth_hole_fill_top.sv */
// Top level of the masked depth hole fill block: fill stage, line store and output register.
//
//   channel   direction  handshake                 payload
//   in        sink       i_in_valid / o_in_stall   i_in_data  (t_in: depth_in, mask_level)
//   out       source     o_out_valid / i_out_stall o_out_data (t_out: depth_out, frame_last)
//   cfg       sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One pixel per clock sustained while the output is not stalled; a pixel passes
// the fill stage, then the output register. The rate is set by the line store:
// one read at input transfer and one write-back as the fill stage advances.
// Reset is synchronous, active low; it clears counters, the left carry and the
// valid flags, and loads geometry 640 x 480. The line store is not cleared.
// An output stall holds the output register; the fill stage then holds too,
// and o_in_stall rises only when both are full.
module masked_depth_hole_fill_top #(
    parameter int MAX_WIDTH  = mdhf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mdhf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mdhf_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mdhf_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic [mdhf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mdhf_pkg::CFG_W-1:0]     i_cfg_data
);
    import mdhf_pkg::*;

    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int RLW = $clog2(MAX_HEIGHT);

    // Handshake.
    logic in_xfer, s1_go, s1_free, out_free;

    // Position of the pixel being transferred in.
    logic [CLW-1:0] col;
    t_pos_flags     flags;

    // Fill stage registers.
    logic               r_s1_vld, n_s1_vld;
    logic [DEPTH_W-1:0] r_s1_depth;
    logic [DEPTH_W-1:0] r_s1_val;
    logic               r_s1_masked;
    logic               r_s1_inner;
    logic               r_s1_last;
    logic [CLW-1:0]     r_s1_idx;
    logic [DEPTH_W-1:0] r_carry;

    logic [DEPTH_W-1:0] above;
    logic [DEPTH_W-1:0] left_filled, final_val;

    // Output register.
    logic r_o_vld, n_o_vld;
    t_out r_o_data;

    assign out_free   = !r_o_vld || !i_out_stall;
    assign s1_go      = r_s1_vld && out_free;
    assign s1_free    = !r_s1_vld || s1_go;
    assign o_in_stall = !s1_free;
    assign in_xfer    = i_in_valid && s1_free;

    mdhf_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CLW        (CLW),
        .RLW        (RLW)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (in_xfer),
        .o_col      (col),
        .o_flags    (flags)
    );

    // Read the pixel above at input transfer; write the final value back when
    // the fill stage advances. Consecutive pixels never share a column, and a
    // pixel's write lands before the next pixel of its column is read, so no
    // forwarding is needed.
    mdhf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CLW)
    ) u_line (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (col),
        .o_rd_data (above),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (final_val)
    );

    // Capture the pixel; a masked-out depth counts as zero for filling.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_depth  <= i_in_data.depth_in;
            r_s1_masked <= i_in_data.mask_level >= MASK_THRESH;
            r_s1_val    <= (i_in_data.mask_level >= MASK_THRESH) ? i_in_data.depth_in
                                                                : '0;
            r_s1_inner  <= flags.inner;
            r_s1_last   <= flags.frame_last;
            r_s1_idx    <= col;
        end
    end

    // Left fill from the carry, then up fill from the line store.
    always_comb begin
        left_filled = (r_s1_inner && (r_s1_val == '0)) ? r_carry : r_s1_val;
        final_val   = (r_s1_inner && (left_filled == '0)) ? above : left_filled;
    end

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (in_xfer) begin
            n_s1_vld = 1'b1;
        end else if (s1_go) begin
            n_s1_vld = 1'b0;
        end
        n_o_vld = r_o_vld;
        if (s1_go) begin
            n_o_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_o_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            r_carry  <= '0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_o_vld  <= n_o_vld;
            if (s1_go) begin
                r_carry <= left_filled;
            end
        end
    end

    // Masked-in pixels give the filled value, others the raw depth.
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_o_data.depth_out  <= r_s1_masked ? final_val : r_s1_depth;
            r_o_data.frame_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o_data;

endmodule
